@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Standalone header with no dependencies; it is taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ design/sfr_pkg.sv @@
// Package for the serial frame receiver: sizes, status codes, register
// indexes and the structs passed between the parser and the result stage.
// No dependencies.
package sfr_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int HEADER_BYTES    = 4;
	localparam int WORD_DEPTH      = (MAX_FRAME_BYTES - HEADER_BYTES) / 2;
	localparam int WORD_AW         = $clog2(WORD_DEPTH);
	localparam int WORD_CW         = $clog2(WORD_DEPTH + 1);
	localparam int POS_W           = 7;
	localparam int BYTE_W          = 8;
	localparam int ID_W            = 16;
	localparam int WORD_W          = 16;
	localparam int COUNT_W         = 8;
	localparam int CFG_W           = 16;
	localparam int RESULT_W        = ID_W + WORD_W + 4;
	localparam int TDATA_W         = ((RESULT_W + 7) / 8) * 8;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_CSUM_ERR = 2'd1;
	localparam logic [1:0] STAT_BAD_LEN  = 2'd2;

	localparam logic REG_SPECIAL_ID  = 1'b0;
	localparam logic REG_FRAME_LIMIT = 1'b1;

	localparam logic [ID_W-1:0]    SPECIAL_ID_RST  = 16'hFFFF;
	localparam logic [COUNT_W-1:0] FRAME_LIMIT_RST = 8'd16;

	typedef struct packed {
		logic               en;
		logic [WORD_AW-1:0] addr;
		logic [WORD_W-1:0]  data;
	} ram_wr_t;

	// Event raised by the parser on a byte that yields results.
	typedef struct packed {
		logic               valid;
		logic               drain;   // results come from the word store
		logic [ID_W-1:0]    dev_id;
		logic [1:0]         status;
		logic               release_ok;
		logic               request;
		logic [WORD_CW-1:0] words;
	} frame_end_t;

endpackage

@@ design/serial_frame_receiver_xor_credit.sv @@
// Top level of the serial frame receiver with XOR checksum and frame credit.
// Depends on sfr_pkg, sfr_ram, sfr_parse and sfr_emit.
//
//   Channel   Direction  Signals                      Payload
//   -------   ---------  ---------------------------  ----------------------------------
//   s_        in         s_tvalid s_tready s_tdata    rx_byte
//   m_        out        m_tvalid m_tready m_tdata    dev_id data_word status is_release
//                        m_tuser m_tlast              request_release, word_valid, last
//   cfg_      in         cfg_valid cfg_ready          cfg_index, cfg_data
//
// A byte is taken whenever the block is idle and its output register is free.
// A byte that closes a frame with payload words and an even payload length starts
// a read-back of the word store, each word going through a registered RAM read
// and then an output load, so input is held off for the read-back plus output
// stalls. Other results are loaded directly. Reset is asynchronous and clears the
// control state; the word store has no reset, as only current words are read.
module serial_frame_receiver_xor_credit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Byte input. s_tdata: rx_byte [7:0].
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sfr_pkg::BYTE_W-1:0]    s_tdata,
	// Results. m_tdata: dev_id [15:0], data_word [31:16], status [33:32],
	// is_release [34], request_release [35], zero fill [39:36].
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sfr_pkg::TDATA_W-1:0]   m_tdata,
	// m_tuser: word_valid [0].
	output logic                          m_tuser,
	output logic                          m_tlast,
	// Register writes: index 0 special_id, index 1 frame_limit (low byte).
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0]     cfg_data
);

	logic [sfr_pkg::ID_W-1:0]    special_id_q;
	logic [sfr_pkg::COUNT_W-1:0] frame_limit_q;

	sfr_pkg::ram_wr_t    wr;
	sfr_pkg::frame_end_t fe;

	logic                         byte_acc;
	logic                         rd_en;
	logic [sfr_pkg::WORD_AW-1:0]  rd_addr;
	logic [sfr_pkg::WORD_W-1:0]   rd_data;

	// Register writes are always taken; software must write only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;
	assign byte_acc  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			special_id_q  <= sfr_pkg::SPECIAL_ID_RST;
			frame_limit_q <= sfr_pkg::FRAME_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfr_pkg::REG_SPECIAL_ID: begin
					special_id_q <= cfg_data;
				end
				sfr_pkg::REG_FRAME_LIMIT: begin
					frame_limit_q <= cfg_data[sfr_pkg::COUNT_W-1:0];
				end
				default: begin
					special_id_q <= special_id_q;
				end
			endcase
		end
	end

	// Frame parsing, checksum and credit counting.
	sfr_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_acc    (byte_acc),
		.rx_byte     (s_tdata),
		.special_id  (special_id_q),
		.frame_limit (frame_limit_q),
		.wr          (wr),
		.fe          (fe)
	);

	// Buffered payload words of the frame in progress.
	sfr_ram #(
		.WIDTH (sfr_pkg::WORD_W),
		.DEPTH (sfr_pkg::WORD_DEPTH)
	) u_words (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result sequencing and output register. Input is held off during
	// read-back, so a store write never meets a read of the same frame.
	sfr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.fe       (fe),
		.rx_ready (s_tready),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ design/sfr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/sfr_parse.sv @@
// Byte parser: tracks the position in the frame, the checksum, the header id
// and the frame counter, writes data words to the store. Depends on sfr_pkg.
module sfr_parse (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_acc,
	input  logic [sfr_pkg::BYTE_W-1:0]      rx_byte,
	input  logic [sfr_pkg::ID_W-1:0]        special_id,
	input  logic [sfr_pkg::COUNT_W-1:0]     frame_limit,
	output sfr_pkg::ram_wr_t                wr,
	output sfr_pkg::frame_end_t             fe
);

	logic [sfr_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [sfr_pkg::POS_W-1:0]   len_q, len_d;
	logic [sfr_pkg::BYTE_W-1:0]  xor_q, xor_d;
	logic [sfr_pkg::ID_W-1:0]    id_q, id_d;
	logic [sfr_pkg::BYTE_W-1:0]  hold_q, hold_d;
	logic [sfr_pkg::COUNT_W-1:0] count_q, count_d;

	logic [sfr_pkg::POS_W-1:0]   pos_m4;
	logic [sfr_pkg::POS_W-1:0]   payload;
	logic [sfr_pkg::COUNT_W-1:0] count_inc;
	logic                        special;
	logic                        good;
	logic                        odd;

	assign pos_m4    = pos_q - sfr_pkg::POS_W'(sfr_pkg::HEADER_BYTES);
	assign payload   = len_q - sfr_pkg::POS_W'(sfr_pkg::HEADER_BYTES);
	assign count_inc = count_q + 1'b1;
	assign special   = (id_q == special_id);
	assign good      = (rx_byte == xor_q);
	assign odd       = payload[0];

	always_comb begin
		pos_d   = pos_q;
		len_d   = len_q;
		xor_d   = xor_q;
		id_d    = id_q;
		hold_d  = hold_q;
		count_d = count_q;
		wr      = '0;
		fe      = '0;
		if (byte_acc) begin
			if (pos_q == '0) begin
				if (rx_byte < sfr_pkg::BYTE_W'(sfr_pkg::HEADER_BYTES) ||
						rx_byte > sfr_pkg::BYTE_W'(sfr_pkg::MAX_FRAME_BYTES)) begin
					// Bad length byte: report at once and stay in sync search.
					fe.valid  = 1'b1;
					fe.status = sfr_pkg::STAT_BAD_LEN;
				end else begin
					len_d = rx_byte[sfr_pkg::POS_W-1:0];
					xor_d = rx_byte;
					pos_d = sfr_pkg::POS_W'(1);
				end
			end else if ({1'b0, pos_q} + 1'b1 < {1'b0, len_q}) begin
				if (pos_q == sfr_pkg::POS_W'(1)) begin
					id_d = {rx_byte, 8'h00};
				end else if (pos_q == sfr_pkg::POS_W'(2)) begin
					id_d = {id_q[15:8], rx_byte};
				end else if (pos_q[0]) begin
					hold_d = rx_byte;
				end else begin
					wr.en   = 1'b1;
					wr.addr = sfr_pkg::WORD_AW'(pos_m4 >> 1);
					wr.data = {hold_q, rx_byte};
				end
				xor_d = xor_q ^ rx_byte;
				pos_d = pos_q + 1'b1;
			end else begin
				// Checksum byte closes the frame.
				pos_d = '0;
				if (!special) begin
					if (count_inc >= frame_limit) begin
						fe.request = 1'b1;
						count_d    = '0;
					end else begin
						count_d = count_inc;
					end
				end
				fe.valid  = 1'b1;
				fe.dev_id = id_q;
				fe.words  = sfr_pkg::WORD_CW'(payload >> 1);
				if (odd) begin
					fe.status = sfr_pkg::STAT_BAD_LEN;
				end else begin
					fe.status     = good ? sfr_pkg::STAT_OK : sfr_pkg::STAT_CSUM_ERR;
					fe.release_ok = good && special;
					fe.drain      = (payload >> 1) != '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			xor_q   <= '0;
			id_q    <= '0;
			hold_q  <= '0;
			count_q <= '0;
		end else begin
			pos_q   <= pos_d;
			len_q   <= len_d;
			xor_q   <= xor_d;
			id_q    <= id_d;
			hold_q  <= hold_d;
			count_q <= count_d;
		end
	end

endmodule

@@ design/sfr_emit.sv @@
// Result stage: output register and the sequencer that reads buffered words
// back from the store at frame end. Depends on sfr_pkg.
module sfr_emit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sfr_pkg::frame_end_t              fe,
	output logic                             rx_ready,
	output logic                             rd_en,
	output logic [sfr_pkg::WORD_AW-1:0]      rd_addr,
	input  logic [sfr_pkg::WORD_W-1:0]       rd_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sfr_pkg::TDATA_W-1:0]      m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);

	typedef enum logic [2:0] {
		EM_IDLE = 3'b001,
		EM_READ = 3'b010,
		EM_LOAD = 3'b100
	} emit_state_t;

	emit_state_t state_q, state_d;

	logic                          out_valid_q;
	logic [sfr_pkg::ID_W-1:0]      out_id_q;
	logic [sfr_pkg::WORD_W-1:0]    out_word_q;
	logic                          out_wv_q;
	logic [1:0]                    out_st_q;
	logic                          out_rel_q;
	logic                          out_req_q;
	logic                          out_last_q;

	logic [sfr_pkg::WORD_AW-1:0]   idx_q;
	logic [sfr_pkg::WORD_CW-1:0]   words_m1_q;
	logic [sfr_pkg::ID_W-1:0]      fr_id_q;
	logic [1:0]                    fr_st_q;
	logic                          fr_rel_q;
	logic                          fr_req_q;

	logic take;
	logic slot_free;
	logic final_word;

	assign take       = out_valid_q && m_tready;
	assign slot_free  = !out_valid_q || m_tready;
	assign final_word = (sfr_pkg::WORD_CW'(idx_q) == words_m1_q);
	assign rx_ready   = (state_q == EM_IDLE) && slot_free;
	assign rd_en      = (state_q == EM_READ) && slot_free;
	assign rd_addr    = idx_q;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_wv_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(sfr_pkg::TDATA_W - sfr_pkg::RESULT_W)'(0),
		out_req_q, out_rel_q, out_st_q, out_word_q, out_id_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			EM_IDLE: begin
				if (fe.valid && fe.drain) begin
					state_d = EM_READ;
				end
			end
			EM_READ: begin
				if (slot_free) begin
					state_d = EM_LOAD;
				end
			end
			EM_LOAD: begin
				state_d = final_word ? EM_IDLE : EM_READ;
			end
			default: begin
				state_d = EM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == EM_IDLE && fe.valid && !fe.drain) || state_q == EM_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == EM_IDLE) begin
				idx_q <= '0;
			end else if (state_q == EM_LOAD) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EM_IDLE && fe.valid) begin
			fr_id_q    <= fe.dev_id;
			fr_st_q    <= fe.status;
			fr_rel_q   <= fe.release_ok;
			fr_req_q   <= fe.request;
			words_m1_q <= fe.words - 1'b1;
			if (!fe.drain) begin
				out_id_q   <= fe.dev_id;
				out_word_q <= '0;
				out_wv_q   <= 1'b0;
				out_st_q   <= fe.status;
				out_rel_q  <= fe.release_ok;
				out_req_q  <= fe.request;
				out_last_q <= 1'b1;
			end
		end else if (state_q == EM_LOAD) begin
			out_id_q   <= fr_id_q;
			out_word_q <= rd_data;
			out_wv_q   <= 1'b1;
			out_st_q   <= fr_st_q;
			out_rel_q  <= final_word && fr_rel_q;
			out_req_q  <= final_word && fr_req_q;
			out_last_q <= final_word;
		end
	end

endmodule

@@ design/sfr_checker.sv @@
// Port-level checker for the serial frame receiver, bound to the top level.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sfr_pkg::TDATA_W-1:0]   m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	logic bad_len;

	assign bad_len = m_tvalid && (m_tdata[33:32] == sfr_pkg::STAT_BAD_LEN);

	// A stalled result stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// Only word results can be followed by more results of the same frame.
	`ASSERT_IMPLIES(a_nonlast_word, clk, arst_n, m_tvalid && !m_tlast, m_tuser)

	// Release flags ride only on the final result of a frame.
	`ASSERT_IMPLIES(a_flags_last, clk, arst_n, m_tvalid && !m_tlast, m_tdata[35:34] == 2'b00)

	// A length error is a single result without a word.
	`ASSERT_IMPLIES(a_badlen_single, clk, arst_n, bad_len, m_tlast && !m_tuser && !m_tdata[34])

	// Status never carries the unused code.
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, m_tvalid, m_tdata[33:32] <= sfr_pkg::STAT_BAD_LEN)

endmodule

bind serial_frame_receiver_xor_credit sfr_checker u_sfr_checker (.*);
